// ----- design/m3h_pkg.sv -----
// m3h_pkg: constants, types and the queue entry format for the MurmurHash3
// x86_32 stream hasher.
// No dependencies; used by every module in design/.
package m3h_pkg;

  localparam logic [31:0] C1 = 32'hcc9e2d51;
  localparam logic [31:0] C2 = 32'h1b873593;
  localparam logic [31:0] C3 = 32'he6546b64;
  localparam logic [31:0] F1 = 32'h85ebca6b;
  localparam logic [31:0] F2 = 32'hc2b2ae35;

  // Word queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  // What the back end does with one scrambled word
  typedef enum logic [1:0] {
    OP_BODY       = 2'd0,  // full word, message continues
    OP_FINAL_FULL = 2'd1,  // full word, then finalize
    OP_FINAL_TAIL = 2'd2,  // 1..3 bytes, tail mix, then finalize
    OP_FINAL_NONE = 2'd3   // no bytes, finalize only
  } m3h_op_e;

  typedef struct packed {
    logic [31:0] k;          // scrambled word: rotl15(w * C1) * C2
    m3h_op_e     op;
    logic [2:0]  add_bytes;  // 0..4
  } m3h_entry_t;

  typedef enum logic [1:0] {
    BS_MIX = 2'd0,
    BS_AV1 = 2'd1,
    BS_AV2 = 2'd2,
    BS_OUT = 2'd3
  } m3h_bstate_e;

endpackage

// ----- design/m3h_front.sv -----
// m3h_front: accepts input words, classifies them and runs the two-stage
// word scramble (multiply, rotate, multiply). Depends on m3h_pkg.
module m3h_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         word_i,
  input  logic [2:0]          count_i,
  input  logic                last_i,
  output logic                push_o,
  output m3h_pkg::m3h_entry_t push_entry_o,
  input  logic                push_ready_i
);

  logic              s1_valid_q, s2_valid_q;
  logic [31:0]       s1_k_q, s2_k_q;
  m3h_pkg::m3h_op_e  s1_op_q, s2_op_q;
  logic [2:0]        s1_add_q, s2_add_q;
  logic              advance;

  logic [31:0]       masked;
  m3h_pkg::m3h_op_e  op_in;
  logic [2:0]        add_in;
  logic [31:0]       rot1;

  assign advance    = !s2_valid_q || push_ready_i;
  assign in_ready_o = advance;

  // classify and mask the tail bytes
  always_comb begin
    masked = word_i;
    op_in  = m3h_pkg::OP_BODY;
    add_in = 3'd4;
    if (last_i) begin
      case (count_i)
        3'd0: begin
          masked = '0;
          op_in  = m3h_pkg::OP_FINAL_NONE;
          add_in = 3'd0;
        end
        3'd1: begin
          masked = {24'd0, word_i[7:0]};
          op_in  = m3h_pkg::OP_FINAL_TAIL;
          add_in = 3'd1;
        end
        3'd2: begin
          masked = {16'd0, word_i[15:0]};
          op_in  = m3h_pkg::OP_FINAL_TAIL;
          add_in = 3'd2;
        end
        3'd3: begin
          masked = {8'd0, word_i[23:0]};
          op_in  = m3h_pkg::OP_FINAL_TAIL;
          add_in = 3'd3;
        end
        default: begin  // four or more: full word
          op_in  = m3h_pkg::OP_FINAL_FULL;
          add_in = 3'd4;
        end
      endcase
    end
  end

  assign rot1 = {s1_k_q[16:0], s1_k_q[31:17]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_k_q   <= masked * m3h_pkg::C1;
      s1_op_q  <= op_in;
      s1_add_q <= add_in;
      s2_k_q   <= rot1 * m3h_pkg::C2;
      s2_op_q  <= s1_op_q;
      s2_add_q <= s1_add_q;
    end
  end

  assign push_o                 = s2_valid_q;
  assign push_entry_o.k         = s2_k_q;
  assign push_entry_o.op        = s2_op_q;
  assign push_entry_o.add_bytes = s2_add_q;

endmodule

// ----- design/m3h_fifo.sv -----
// m3h_fifo: short queue of scrambled words between front and back end.
// Depends on m3h_pkg.
module m3h_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  m3h_pkg::m3h_entry_t push_entry_i,
  output logic                push_ready_o,
  output logic                pop_valid_o,
  output m3h_pkg::m3h_entry_t pop_entry_o,
  input  logic                pop_i
);

  m3h_pkg::m3h_entry_t       mem_q [m3h_pkg::QDepth];
  logic [m3h_pkg::QAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [m3h_pkg::QAw:0]     fill_q;
  logic                      do_push, do_pop;

  assign push_ready_o = (fill_q != (m3h_pkg::QAw+1)'(m3h_pkg::QDepth));
  assign pop_valid_o  = (fill_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      fill_q <= fill_q + 1'b1;
      else if (do_pop && !do_push) fill_q <= fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_entry_i;
  end

endmodule

// ----- design/m3h_back.sv -----
// m3h_back: hash recurrence, length count, fmix32 avalanche and the result
// register. Depends on m3h_pkg.
module m3h_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         seed_i,
  input  logic                pop_valid_i,
  input  m3h_pkg::m3h_entry_t pop_entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         out_hash_o,
  output logic [31:0]         out_len_o
);

  m3h_pkg::m3h_bstate_e state_q, state_d;
  logic [31:0] h_q, h_d, total_q, total_d;
  logic        in_msg_q, in_msg_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_hash_q, out_hash_d, out_len_q, out_len_d;

  logic [31:0] h_base, t_base, hx, hr, x1, x2;

  assign h_base = in_msg_q ? h_q : seed_i;
  assign t_base = in_msg_q ? total_q : '0;
  assign hx     = h_base ^ pop_entry_i.k;
  assign hr     = {hx[18:0], hx[31:19]};
  assign x1     = h_q ^ total_q;
  assign x2     = h_q;

  always_comb begin
    state_d     = state_q;
    h_d         = h_q;
    total_d     = total_q;
    in_msg_d    = in_msg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_hash_d  = out_hash_q;
    out_len_d   = out_len_q;
    pop_o       = 1'b0;
    case (state_q)
      m3h_pkg::BS_MIX: begin
        if (pop_valid_i) begin
          pop_o    = 1'b1;
          in_msg_d = 1'b1;
          total_d  = t_base + {29'd0, pop_entry_i.add_bytes};
          case (pop_entry_i.op)
            m3h_pkg::OP_BODY: begin
              h_d = (hr << 2) + hr + m3h_pkg::C3;
            end
            m3h_pkg::OP_FINAL_FULL: begin
              h_d     = (hr << 2) + hr + m3h_pkg::C3;
              state_d = m3h_pkg::BS_AV1;
            end
            m3h_pkg::OP_FINAL_TAIL: begin
              h_d     = hx;
              state_d = m3h_pkg::BS_AV1;
            end
            default: begin  // no tail bytes
              h_d     = h_base;
              state_d = m3h_pkg::BS_AV1;
            end
          endcase
        end
      end
      m3h_pkg::BS_AV1: begin
        h_d     = (x1 ^ (x1 >> 16)) * m3h_pkg::F1;
        state_d = m3h_pkg::BS_AV2;
      end
      m3h_pkg::BS_AV2: begin
        h_d     = (x2 ^ (x2 >> 13)) * m3h_pkg::F2;
        state_d = m3h_pkg::BS_OUT;
      end
      m3h_pkg::BS_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          h_d         = h_q ^ (h_q >> 16);
          out_hash_d  = h_q ^ (h_q >> 16);
          out_len_d   = total_q;
          out_valid_d = 1'b1;
          in_msg_d    = 1'b0;
          state_d     = m3h_pkg::BS_MIX;
        end
      end
      default: state_d = m3h_pkg::BS_MIX;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= m3h_pkg::BS_MIX;
      in_msg_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_msg_q    <= in_msg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q        <= h_d;
    total_q    <= total_d;
    out_hash_q <= out_hash_d;
    out_len_q  <= out_len_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_hash_o  = out_hash_q;
  assign out_len_o   = out_len_q;

endmodule

// ----- design/murmur3_hash32_stream.sv -----
// murmur3_hash32_stream: MurmurHash3 x86_32 over a stream of little-endian
// 32-bit words. Depends on m3h_pkg, m3h_front, m3h_fifo and m3h_back.
//
// Each input transfer carries one message word, its valid byte count and a
// last mark; one output transfer with the hash and the byte length follows
// every last transfer. The front end takes a word every cycle unless the
// queue is full, and scrambles it in two multiply stages; a four-entry
// queue feeds the back end, which folds one word a cycle into the running
// hash (xor, rotate, times five, add) and counts bytes. A last word takes
// the back end through the fold, two avalanche multiplies and the load of
// the result register, which waits while the output is stalled; the back
// end takes no new word meanwhile.
// Non-last words always count as four bytes; on the last word counts above
// four saturate to four and bytes above the count are ignored. The seed
// written over the configuration channel is loaded at each message start;
// write it only while no message is in flight. The length wraps at 2^32.
module murmur3_hash32_stream (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: hash_seed
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] data_word, [34:32] valid_bytes, zero fill
  input  logic        s_axis_tlast,   // last_word
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [31:0] hash_value, [63:32] message_length
);

  logic [31:0]         seed_q;
  logic                push, push_ready, pop_valid, pop;
  m3h_pkg::m3h_entry_t push_entry, pop_entry;
  logic [31:0]         out_hash, out_len;

  // seed register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_valid_i) begin
      seed_q <= cfg_data_i;
    end
  end

  m3h_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .word_i       (s_axis_tdata[31:0]),
    .count_i      (s_axis_tdata[34:32]),
    .last_i       (s_axis_tlast),
    .push_o       (push),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  m3h_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .pop_i        (pop)
  );

  m3h_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_i      (seed_q),
    .pop_valid_i (pop_valid),
    .pop_entry_i (pop_entry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_hash_o  (out_hash),
    .out_len_o   (out_len)
  );

  assign m_axis_tdata = {out_len, out_hash};

endmodule

// ----- test/tb.sv -----
// tb: self-checking testbench for murmur3_hash32_stream (MurmurHash3 x86_32).
// Depends on m3h_pkg and the design/ sources; runs stand-alone, no files or args.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous watchdog: far above what the slowest legal run needs.
  localparam int unsigned CycleLimit  = 200_000;
  // Extra wait after the last owed result has come out.
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned PhaseWords  = 258;

  // One finished hash as the block reports it.
  typedef struct packed {
    logic [31:0] hash;
    logic [31:0] len;
  } digest_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // [31:0] data_word, [34:32] valid_bytes, zero fill
  logic        s_axis_tlast;   // last_word
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // [31:0] hash_value, [63:32] message_length

  // Predictor state, mirrors the hasher's architectural state.
  logic [31:0] seed_q;
  logic [31:0] run_hash;
  logic [31:0] byte_cnt;
  logic        in_msg;
  digest_t     hash_q[$];      // hashes owed by the block, oldest first

  // Bookkeeping for the summary
  int unsigned words_sent;
  int unsigned msgs_sent;
  int unsigned hashes_seen;
  int unsigned seeds_written;
  int unsigned fail_cnt;
  int unsigned cycles;
  // Last stretch of the run: no gaps on the input, no stalls on the output.
  logic        calm;

  murmur3_hash32_stream u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Hash arithmetic
  // ---------------------------------------------------------------------

  // k * c1, rotate left 15, * c2
  function automatic logic [31:0] scramble_k(input logic [31:0] w);
    logic [31:0] k;
    k = w * m3h_pkg::C1;
    k = {k[16:0], k[31:17]};
    return k * m3h_pkg::C2;
  endfunction

  // Body round: xor in the scrambled word, rotate left 13, h*5 + c3
  function automatic logic [31:0] fold_word(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] x;
    x = h ^ scramble_k(w);
    x = {x[18:0], x[31:19]};
    return x * 32'd5 + m3h_pkg::C3;
  endfunction

  // fmix32 finalizer
  function automatic logic [31:0] avalanche_32(input logic [31:0] h);
    logic [31:0] x;
    x = (h ^ (h >> 16)) * m3h_pkg::F1;
    x = (x ^ (x >> 13)) * m3h_pkg::F2;
    return x ^ (x >> 16);
  endfunction

  // Advance the predicted state by one accepted word; a last word closes the
  // message and queues the hash the block owes us.
  task automatic predict_word(input logic [31:0] w, input logic [2:0] nb, input logic lst);
    logic [2:0]  n;
    logic [31:0] mask;
    digest_t     d;
    if (!in_msg) begin
      run_hash = seed_q;
      byte_cnt = '0;
      in_msg   = 1'b1;
    end
    if (!lst) begin
      // count is don't-care mid-message, always four bytes
      run_hash = fold_word(run_hash, w);
      byte_cnt = byte_cnt + 32'd4;
    end else begin
      n = (nb > 3'd4) ? 3'd4 : nb;   // 5..7 saturate
      if (n == 3'd4) begin
        run_hash = fold_word(run_hash, w);
      end else if (n != 3'd0) begin
        // tail mix: bytes above the count are masked off, no rotate/add
        mask     = (32'd1 << (8 * n)) - 32'd1;
        run_hash = run_hash ^ scramble_k(w & mask);
      end
      byte_cnt = byte_cnt + {29'd0, n};
      run_hash = avalanche_32(run_hash ^ byte_cnt);
      d.hash   = run_hash;
      d.len    = byte_cnt;
      hash_q.push_back(d);
      in_msg   = 1'b0;
      msgs_sent++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // One word transfer. Sometimes idles first for a short burst; valid stays
  // high afterwards so back-to-back words need no extra NBA in one step.
  task automatic push_word(input logic [31:0] w, input logic [2:0] nb, input logic lst);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, nb, w};
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_word(w, nb, lst);
    words_sent++;
  endtask

  // Stop the stream and let every owed hash come out, then give the back
  // end time to settle before anything touches the seed.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (hash_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Seed write, only ever with no message in flight.
  task automatic write_seed(input logic [31:0] s);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= s;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    seed_q = s;
    seeds_written++;
  endtask

  // Mostly random words, with the all-zero and all-one words mixed in.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Whole message: body words with junk counts, then the closing word.
  task automatic send_message(input int unsigned body_words, input logic [2:0] tail_cnt);
    for (int unsigned i = 0; i < body_words; i++)
      push_word(rand_word(), 3'($urandom_range(0, 7)), 1'b0);
    push_word(rand_word(), tail_cnt, 1'b1);
  endtask

  // ---------------------------------------------------------------------
  // Output side: random ready stalls, compare every transfer in order
  // ---------------------------------------------------------------------

  task automatic check_digest(input logic [63:0] t);
    digest_t d;
    if (hash_q.size() == 0) begin
      $error("result with nothing pending: hash_value %h message_length %0d",
             t[31:0], t[63:32]);
      fail_cnt++;
    end else begin
      d = hash_q.pop_front();
      if (t[31:0] !== d.hash) begin
        $error("hash_value: expected %h, got %h", d.hash, t[31:0]);
        fail_cnt++;
      end
      if (t[63:32] !== d.len) begin
        $error("message_length: expected %0d, got %0d", d.len, t[63:32]);
        fail_cnt++;
      end
      hashes_seen++;
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    stall         = 0;
    m_axis_tready = 1'b1;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_digest(m_axis_tdata);
      if (calm) begin
        stall = 0;
        m_axis_tready <= 1'b1;
      end else if (stall != 0) begin
        stall--;
        if (stall == 0) m_axis_tready <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 10);
        m_axis_tready <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d hashes still pending", cycles, hash_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Seed straight out of reset (zero), plus an empty message that only
  // finalizes.
  task automatic test_default_seed();
    push_word(32'h0000_0000, 3'd4, 1'b1);
    push_word(32'hdead_beef, 3'd0, 1'b1);
  endtask

  // Every count on a one-word message, junk in the bytes above the count;
  // 5..7 must behave like 4.
  task automatic test_tail_counts();
    write_seed(32'hffff_ffff);
    for (int unsigned c = 0; c < 8; c++)
      push_word((c % 2 == 0) ? 32'hffff_ffff : 32'h5a3c_96e1, 3'(c), 1'b1);
  endtask

  // Counts on body words are ignored; always four bytes.
  task automatic test_ignored_counts();
    write_seed(32'h0000_0000);
    push_word(32'h0403_0201, 3'd0, 1'b0);
    push_word(32'h0807_0605, 3'd5, 1'b0);
    push_word(32'h0c0b_0a09, 3'd7, 1'b0);
    push_word(32'hff0f_0e0d, 3'd3, 1'b1);
  endtask

  // All-zero and all-one words in body and closing position.
  task automatic test_word_extremes();
    write_seed(32'h9747_b28c);
    push_word(32'h0000_0000, 3'd0, 1'b0);
    push_word(32'hffff_ffff, 3'd2, 1'b0);
    push_word(32'h0000_0000, 3'd4, 1'b1);
    push_word(32'hffff_ffff, 3'd4, 1'b1);
  endtask

  // Random messages, mostly short, now and then a long one.
  task automatic test_random_traffic(input logic [31:0] s, input int unsigned n);
    int unsigned start;
    int unsigned len;
    write_seed(s);
    start = words_sent;
    while (words_sent - start < n) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 6);
      send_message(len, 3'($urandom_range(0, 7)));
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    calm          = 1'b0;
    seed_q        = '0;
    run_hash      = '0;
    byte_cnt      = '0;
    in_msg        = 1'b0;
    words_sent    = 0;
    msgs_sent     = 0;
    hashes_seen   = 0;
    seeds_written = 0;
    fail_cnt      = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_seed();
    test_tail_counts();
    test_ignored_counts();
    test_word_extremes();

    test_random_traffic($urandom, PhaseWords);
    test_random_traffic(32'h0000_0000, PhaseWords);
    test_random_traffic(32'hffff_ffff, PhaseWords);
    // final stretch runs at full rate on both sides
    calm = 1'b1;
    test_random_traffic($urandom, PhaseWords);

    wait_drained();

    $display("sent %0d words in %0d messages under %0d seed settings", words_sent,
             msgs_sent, seeds_written + 1);
    $display("compared %0d hashes, %0d mismatches", hashes_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- murmur3_hash32_stream.f -----
design/m3h_pkg.sv
design/m3h_front.sv
design/m3h_fifo.sv
design/m3h_back.sv
design/murmur3_hash32_stream.sv
test/tb.sv
